>>> sv/assert_macros.svh
// Assertion macros shared by the line discipline queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TLQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tlq assertion failed");
// Condition must never be true outside reset.
`define TLQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tlq forbidden condition seen");
`else
`define TLQ_ASSERT(label, clk, rst_n, prop)
`define TLQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> sv/tlq_pkg.sv
// Shared types, constants and helpers of the line discipline queues.
package tlq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic [1:0] CFG_CR_TO_LF   = 2'd0;
    localparam logic [1:0] CFG_ECHO       = 2'd1;
    localparam logic [1:0] CFG_LF_TO_CRLF = 2'd2;
    localparam logic [1:0] CFG_CANONICAL  = 2'd3;

    typedef enum logic [1:0] {
        CMD_TERM_WRITE = 2'd0,
        CMD_TERM_READ  = 2'd1,
        CMD_PROC_WRITE = 2'd2,
        CMD_PROC_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } state_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic echo_and_push;
        logic cr_push;
        logic byte_push;
        logic read_issue;
        logic read_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic out_free;
    } dp_status_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> sv/tlq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/tlq_ctrl.sv
// Controller state machine that sequences the steps of one command.
`include "assert_macros.svh"
module tlq_ctrl
    import tlq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (status.cmd != CMD_TERM_WRITE)
                begin
                    state_next = ST_SECOND;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The final step of a command only fires once the result register is free,
    // so no push or pop is repeated while the output stalls.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_FIRST:
            begin
                case (status.cmd)
                    CMD_TERM_WRITE: cmd.echo_and_push = status.out_free;
                    CMD_PROC_WRITE: cmd.cr_push       = 1'b1;
                    default:        cmd.read_issue    = 1'b1;
                endcase
            end
            ST_SECOND:
            begin
                if (status.cmd == CMD_PROC_WRITE)
                begin
                    cmd.byte_push = status.out_free;
                end
                else
                begin
                    cmd.read_finish = status.out_free;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `TLQ_ASSERT(a_one_step, clk, rst_n, $onehot0(cmd))
    `TLQ_ASSERT(a_first_follows_latch, clk, rst_n, cmd.latch |=> state_reg == ST_FIRST)

endmodule

>>> sv/tlq_datapath.sv
// Datapath: configuration, ring pointers, queue RAMs and the result register.
`include "assert_macros.svh"
module tlq_datapath
    import tlq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accepted,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic       line_end,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status
);

    logic cr_to_lf_reg, echo_reg, lf_to_crlf_reg, canonical_reg;

    cmd_t       cmd_reg, cmd_next;
    logic [7:0] byte_reg, byte_next;
    logic       rd_hit_reg, rd_hit_next;

    ptr_t proc_head_reg, proc_head_next, proc_tail_reg, proc_tail_next;
    ptr_t term_head_reg, term_head_next, term_tail_reg, term_tail_next;

    logic       out_valid_reg, out_valid_next;
    logic       accepted_reg, accepted_next;
    logic       read_valid_reg, read_valid_next;
    logic [7:0] read_byte_reg, read_byte_next;
    logic       line_end_reg, line_end_next;

    logic       proc_full, proc_empty, term_full, term_empty;
    logic       proc_wr, proc_rd, term_wr, term_rd;
    logic       echo_wr, cr_wr, bp_wr;
    logic [7:0] term_wr_data;
    logic [7:0] proc_rd_data, term_rd_data, rd_data;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_to_lf_reg   <= 1'b1;
            echo_reg       <= 1'b1;
            lf_to_crlf_reg <= 1'b1;
            canonical_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CR_TO_LF:   cr_to_lf_reg   <= cfg_data;
                CFG_ECHO:       echo_reg       <= cfg_data;
                CFG_LF_TO_CRLF: lf_to_crlf_reg <= cfg_data;
                CFG_CANONICAL:  canonical_reg  <= cfg_data;
                default:        canonical_reg  <= canonical_reg;
            endcase
        end
    end

    assign proc_full  = ptr_next(proc_head_reg) == proc_tail_reg;
    assign proc_empty = proc_head_reg == proc_tail_reg;
    assign term_full  = ptr_next(term_head_reg) == term_tail_reg;
    assign term_empty = term_head_reg == term_tail_reg;

    // The to-terminal queue takes at most one byte per cycle: echo, the
    // inserted CR and the process byte fall in different steps.
    assign echo_wr = cmd.echo_and_push && echo_reg && !term_full;
    assign cr_wr   = cmd.cr_push && lf_to_crlf_reg && (byte_reg == BYTE_LF) && !term_full;
    assign bp_wr   = cmd.byte_push && !term_full;
    assign term_wr = echo_wr || cr_wr || bp_wr;
    assign term_wr_data = cr_wr ? BYTE_CR : byte_reg;

    assign proc_wr = cmd.echo_and_push && !proc_full;
    assign proc_rd = cmd.read_issue && (cmd_reg == CMD_PROC_READ) && !proc_empty;
    assign term_rd = cmd.read_issue && (cmd_reg == CMD_TERM_READ) && !term_empty;

    assign rd_data = (cmd_reg == CMD_TERM_READ) ? term_rd_data : proc_rd_data;
    assign load    = cmd.echo_and_push || cmd.byte_push || cmd.read_finish;

    always_comb
    begin
        cmd_next  = cmd_reg;
        byte_next = byte_reg;
        if (cmd.latch)
        begin
            cmd_next  = cmd_t'(command);
            byte_next = data_byte;
            if ((cmd_t'(command) == CMD_TERM_WRITE) && cr_to_lf_reg && (data_byte == BYTE_CR))
            begin
                byte_next = BYTE_LF;
            end
        end
        rd_hit_next    = cmd.read_issue ? (proc_rd || term_rd) : rd_hit_reg;
        proc_head_next = proc_wr ? ptr_next(proc_head_reg) : proc_head_reg;
        proc_tail_next = proc_rd ? ptr_next(proc_tail_reg) : proc_tail_reg;
        term_head_next = term_wr ? ptr_next(term_head_reg) : term_head_reg;
        term_tail_next = term_rd ? ptr_next(term_tail_reg) : term_tail_reg;

        out_valid_next  = load || (out_valid_reg && !out_ready);
        accepted_next   = accepted_reg;
        read_valid_next = read_valid_reg;
        read_byte_next  = read_byte_reg;
        line_end_next   = line_end_reg;
        if (load)
        begin
            accepted_next   = (cmd.echo_and_push && !proc_full) || bp_wr;
            read_valid_next = cmd.read_finish && rd_hit_reg;
            read_byte_next  = (cmd.read_finish && rd_hit_reg) ? rd_data : 8'h00;
            line_end_next   = cmd.read_finish && rd_hit_reg && (cmd_reg == CMD_PROC_READ)
                              && canonical_reg && (rd_data == BYTE_LF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_head_reg <= '0;
            proc_tail_reg <= '0;
            term_head_reg <= '0;
            term_tail_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            proc_head_reg <= proc_head_next;
            proc_tail_reg <= proc_tail_next;
            term_head_reg <= term_head_next;
            term_tail_reg <= term_tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        byte_reg       <= byte_next;
        rd_hit_reg     <= rd_hit_next;
        accepted_reg   <= accepted_next;
        read_valid_reg <= read_valid_next;
        read_byte_reg  <= read_byte_next;
        line_end_reg   <= line_end_next;
    end

    tlq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_proc_ram (
        .clk     (clk),
        .wr_en   (proc_wr),
        .wr_addr (proc_head_reg),
        .wr_data (byte_reg),
        .rd_en   (proc_rd),
        .rd_addr (proc_tail_reg),
        .rd_data (proc_rd_data)
    );

    tlq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_term_ram (
        .clk     (clk),
        .wr_en   (term_wr),
        .wr_addr (term_head_reg),
        .wr_data (term_wr_data),
        .rd_en   (term_rd),
        .rd_addr (term_tail_reg),
        .rd_data (term_rd_data)
    );

    assign status.cmd      = cmd_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign accepted   = accepted_reg;
    assign read_valid = read_valid_reg;
    assign read_byte  = read_byte_reg;
    assign line_end   = line_end_reg;

    `TLQ_ASSERT_NEVER(a_no_overwrite, clk, rst_n, load && out_valid_reg && !out_ready)
    `TLQ_ASSERT(a_term_push_nonempty, clk, rst_n, term_wr |=> term_head_reg != term_tail_reg)
    `TLQ_ASSERT(a_proc_push_nonempty, clk, rst_n, proc_wr |=> proc_head_reg != proc_tail_reg)
    `TLQ_ASSERT(a_miss_is_zero, clk, rst_n,
        (out_valid_reg && !read_valid_reg) |-> (read_byte_reg == 8'h00 && !line_end_reg))

endmodule

>>> sv/terminal_line_discipline_queues.sv
// Top level of the terminal line discipline queues.
// Two 256-byte ring queues, each holding up to 255 bytes: commands are
// terminal write, terminal read, process write and process read, one result
// per command. A terminal write places its result from the FIRST step; the
// other commands need the SECOND step too, because the inserted CR and the
// written byte share the single write port of the to-terminal RAM and a pop
// waits for the registered RAM read. A stalled result holds back the final
// step, and the next command is taken once the current one has placed its
// result. Queue storage needs no clearing after reset. Configuration writes
// take effect at once and belong in idle periods.
module terminal_line_discipline_queues
    import tlq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accepted,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic       line_end
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tlq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tlq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .read_valid (read_valid),
        .read_byte  (read_byte),
        .line_end   (line_end),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
